/* design/hvn_pkg.sv */
// Shared constants for the heightfield vertex normal unit.
// Used by hvn_norm and heightfield_vertex_normal_unit; no dependencies.
package hvn_pkg;

    localparam int GRID_SIDE_MAX_DEF = 1024;
    localparam int HEIGHT_WIDTH_DEF  = 16;

    localparam int REG_W     = 11;
    localparam int POS_W     = 10;
    localparam int CFG_IDX_W = 1;

    localparam logic [CFG_IDX_W-1:0] CFG_GRID_WIDTH  = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_GRID_HEIGHT = 1'b1;

    // one grid step in Q8.8; triangle vectors are carried divided by it
    localparam int GRID_STEP = 256;
    localparam int NUM_TRI   = 6;

    localparam int NORM_W    = 16;
    localparam int MANT_W    = 20;
    localparam int SQ_W      = 2 * MANT_W;
    localparam int SUM_W     = SQ_W + 2;
    localparam int RAD_W     = SUM_W + MANT_W;
    localparam int ROOT_W    = RAD_W / 2;
    localparam int REM_W     = ROOT_W + 3;
    localparam int NUM_SHIFT = 25;
    localparam int NUM_W     = MANT_W + NUM_SHIFT + 1;
    localparam int DREM_W    = ROOT_W + 1;
    localparam int NSUM_W    = NORM_W + 4;

    // front end, square/sum, root bits, numerator, quotient bits, output
    localparam int NORM_LAT  = 5 + ROOT_W + 1 + NORM_W + 1;

endpackage

/* design/heightfield_vertex_normal_unit.sv */
// Channel   | direction | signals
// request   | in        | i_valid / o_ready, i_row, i_col, seven heights
// result    | out       | o_valid / i_ready, o_normal_x/y/z, o_invalid
// config    | in        | i_cfg_we, i_cfg_idx, i_cfg_data (no handshake)
//
// One request per cycle while o_ready is high. Each request passes through the
// two chained normalizers (31-stage square root, 16-stage divider each).
// Reset clears all valid bits and loads both grid sides with GRID_SIDE_MAX.
// On a held result the pipeline stops as a whole; empty slots still drain.
// Depends on hvn_pkg and hvn_norm.
module heightfield_vertex_normal_unit #(
    parameter int GRID_SIDE_MAX = hvn_pkg::GRID_SIDE_MAX_DEF,
    parameter int HEIGHT_WIDTH  = hvn_pkg::HEIGHT_WIDTH_DEF
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_cfg_we,
    input  logic [hvn_pkg::CFG_IDX_W-1:0]       i_cfg_idx,
    input  logic [hvn_pkg::REG_W-1:0]           i_cfg_data,
    input  logic                                i_valid,
    output logic                                o_ready,
    input  logic [hvn_pkg::POS_W-1:0]           i_row,
    input  logic [hvn_pkg::POS_W-1:0]           i_col,
    input  logic signed [HEIGHT_WIDTH-1:0]      i_center_height,
    input  logic signed [HEIGHT_WIDTH-1:0]      i_north_height,
    input  logic signed [HEIGHT_WIDTH-1:0]      i_north_east_height,
    input  logic signed [HEIGHT_WIDTH-1:0]      i_east_height,
    input  logic signed [HEIGHT_WIDTH-1:0]      i_south_height,
    input  logic signed [HEIGHT_WIDTH-1:0]      i_south_west_height,
    input  logic signed [HEIGHT_WIDTH-1:0]      i_west_height,
    output logic                                o_valid,
    input  logic                                i_ready,
    output logic signed [hvn_pkg::NORM_W-1:0]   o_normal_x,
    output logic signed [hvn_pkg::NORM_W-1:0]   o_normal_y,
    output logic signed [hvn_pkg::NORM_W-1:0]   o_normal_z,
    output logic                                o_invalid
);

    localparam int TW      = HEIGHT_WIDTH + 2;
    localparam int LAT     = hvn_pkg::NORM_LAT;
    localparam int NUM_TRI = hvn_pkg::NUM_TRI;
    localparam int NORM_W  = hvn_pkg::NORM_W;
    localparam int NSUM_W  = hvn_pkg::NSUM_W;
    localparam int REG_W   = hvn_pkg::REG_W;
    localparam logic [TW-1:0] TRI_Y = TW'(-hvn_pkg::GRID_STEP);

    function automatic logic [TW-1:0] f_diff(input logic [HEIGHT_WIDTH-1:0] a,
                                             input logic [HEIGHT_WIDTH-1:0] b);
        f_diff = {{2{a[HEIGHT_WIDTH-1]}}, a} - {{2{b[HEIGHT_WIDTH-1]}}, b};
    endfunction

    // configuration
    logic [REG_W-1:0] r_grid_w;
    logic [REG_W-1:0] r_grid_h;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_grid_w <= REG_W'(GRID_SIDE_MAX);
            r_grid_h <= REG_W'(GRID_SIDE_MAX);
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                hvn_pkg::CFG_GRID_WIDTH:  r_grid_w <= i_cfg_data;
                hvn_pkg::CFG_GRID_HEIGHT: r_grid_h <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // flow control
    logic v_adv;
    logic v_out_free;
    logic r_va;
    logic [LAT-1:0] r_vl;
    logic r_vs;
    logic [LAT-1:0] r_vf;
    logic r_o_valid;

    assign v_out_free = !r_o_valid || i_ready;
    assign v_adv      = v_out_free || !r_vf[LAT-1];
    assign o_ready    = v_adv;
    assign o_valid    = r_o_valid;

    // stage A: grid checks and triangle vectors (scaled by one grid step)
    logic [REG_W-1:0]        v_row;
    logic [REG_W-1:0]        v_col;
    logic                    v_inside;
    logic                    v_has_n;
    logic                    v_has_s;
    logic                    v_has_w;
    logic                    v_has_e;
    logic [NUM_TRI-1:0]      n_a_mask;
    logic [2:0][TW-1:0]      n_a_vec [NUM_TRI];
    logic [NUM_TRI-1:0]      r_a_mask;
    logic                    r_a_bad;
    logic [2:0][TW-1:0]      r_a_vec [NUM_TRI];

    always_comb begin
        v_row    = REG_W'(i_row);
        v_col    = REG_W'(i_col);
        v_inside = (v_row < r_grid_h) && (v_col < r_grid_w);
        v_has_n  = (i_row != '0);
        v_has_w  = (i_col != '0);
        v_has_s  = (v_row + 1'b1) < r_grid_h;
        v_has_e  = (v_col + 1'b1) < r_grid_w;

        n_a_mask[0] = v_inside && v_has_n && v_has_w;
        n_a_mask[1] = v_inside && v_has_n && v_has_e;
        n_a_mask[2] = v_inside && v_has_n && v_has_e;
        n_a_mask[3] = v_inside && v_has_s && v_has_e;
        n_a_mask[4] = v_inside && v_has_s && v_has_w;
        n_a_mask[5] = v_inside && v_has_s && v_has_w;

        // west x north
        n_a_vec[0][0] = f_diff(i_center_height, i_west_height);
        n_a_vec[0][2] = f_diff(i_center_height, i_north_height);
        // north x north-east
        n_a_vec[1][0] = f_diff(i_north_east_height, i_north_height);
        n_a_vec[1][2] = f_diff(i_center_height, i_north_height);
        // north-east x east
        n_a_vec[2][0] = f_diff(i_east_height, i_center_height);
        n_a_vec[2][2] = f_diff(i_east_height, i_north_east_height);
        // east x south
        n_a_vec[3][0] = f_diff(i_east_height, i_center_height);
        n_a_vec[3][2] = f_diff(i_south_height, i_center_height);
        // south x south-west
        n_a_vec[4][0] = f_diff(i_south_height, i_south_west_height);
        n_a_vec[4][2] = f_diff(i_south_height, i_center_height);
        // south-west x west
        n_a_vec[5][0] = f_diff(i_center_height, i_west_height);
        n_a_vec[5][2] = f_diff(i_south_west_height, i_west_height);
        for (int t = 0; t < NUM_TRI; t++) begin
            n_a_vec[t][1] = TRI_Y;
        end
    end

    always_ff @(posedge i_clk) begin
        if (v_adv) begin
            r_a_mask <= n_a_mask;
            r_a_bad  <= (n_a_mask == '0);
            r_a_vec  <= n_a_vec;
        end
    end

    // per-triangle unit normals
    logic [2:0][NORM_W-1:0] v_tri_n [NUM_TRI];

    for (genvar t = 0; t < NUM_TRI; t++) begin : g_tri
        hvn_norm #(
            .W (TW)
        ) u_norm (
            .i_clk  (i_clk),
            .i_en   (v_adv),
            .i_vec  (r_a_vec[t]),
            .o_vec  (v_tri_n[t]),
            .o_zero ()
        );
    end

    logic [NUM_TRI-1:0] r_ml [LAT];
    logic [LAT-1:0]     r_bl;

    always_ff @(posedge i_clk) begin
        if (v_adv) begin
            r_ml[0] <= r_a_mask;
            for (int j = 1; j < LAT; j++) begin
                r_ml[j] <= r_ml[j-1];
            end
            r_bl <= {r_bl[LAT-2:0], r_a_bad};
        end
    end

    // sum of the used unit normals, negated
    logic [NSUM_W-1:0]      v_acc;
    logic [2:0][NSUM_W-1:0] n_s_vec;
    logic [2:0][NSUM_W-1:0] r_s_vec;
    logic                   r_s_bad;

    always_comb begin
        v_acc = '0;
        for (int c = 0; c < 3; c++) begin
            v_acc = '0;
            for (int t = 0; t < NUM_TRI; t++) begin
                if (r_ml[LAT-1][t]) begin
                    v_acc = v_acc + {{(NSUM_W-NORM_W){v_tri_n[t][c][NORM_W-1]}}, v_tri_n[t][c]};
                end
            end
            n_s_vec[c] = '0 - v_acc;
        end
    end

    always_ff @(posedge i_clk) begin
        if (v_adv) begin
            r_s_vec <= n_s_vec;
            r_s_bad <= r_bl[LAT-1];
        end
    end

    // vertex normal
    logic [2:0][NORM_W-1:0] v_fin_n;
    logic                   v_fin_zero;
    logic [LAT-1:0]         r_fb;

    hvn_norm #(
        .W (NSUM_W)
    ) u_norm_vertex (
        .i_clk  (i_clk),
        .i_en   (v_adv),
        .i_vec  (r_s_vec),
        .o_vec  (v_fin_n),
        .o_zero (v_fin_zero)
    );

    always_ff @(posedge i_clk) begin
        if (v_adv) begin
            r_fb <= {r_fb[LAT-2:0], r_s_bad};
        end
    end

    // valid bits
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_va      <= 1'b0;
            r_vl      <= '0;
            r_vs      <= 1'b0;
            r_vf      <= '0;
            r_o_valid <= 1'b0;
        end else begin
            if (v_adv) begin
                r_va <= i_valid;
                r_vl <= {r_vl[LAT-2:0], r_va};
                r_vs <= r_vl[LAT-1];
                r_vf <= {r_vf[LAT-2:0], r_vs};
            end
            if (v_out_free) begin
                r_o_valid <= r_vf[LAT-1];
            end
        end
    end

    // output register
    logic                   v_bad;
    logic [2:0][NORM_W-1:0] r_o_n;
    logic                   r_o_invalid;

    assign v_bad = r_fb[LAT-1] || v_fin_zero;

    always_ff @(posedge i_clk) begin
        if (v_out_free) begin
            r_o_n       <= v_bad ? '0 : v_fin_n;
            r_o_invalid <= v_bad;
        end
    end

    assign o_normal_x = r_o_n[0];
    assign o_normal_y = r_o_n[1];
    assign o_normal_z = r_o_n[2];
    assign o_invalid  = r_o_invalid;

`ifndef SYNTH
    a_invalid_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_invalid |-> (o_normal_x == '0) && (o_normal_y == '0) && (o_normal_z == '0))
        else $error("invalid result with nonzero normal");

    a_normal_up: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !o_invalid |-> !o_normal_y[NORM_W-1])
        else $error("valid normal points down");

    a_off_grid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid && o_ready && ((REG_W'(i_row) >= r_grid_h) || (REG_W'(i_col) >= r_grid_w))
        |=> r_a_bad)
        else $error("off-grid request not flagged");
`endif

endmodule

/* design/hvn_norm.sv */
// Pipelined vector normalizer: scales a signed 3-vector to unit length in Q1.15.
// Depends on hvn_pkg. Stages advance only while i_en is high; no control state.
module hvn_norm #(
    parameter int W = 20
) (
    input  logic                            i_clk,
    input  logic                            i_en,
    input  logic [2:0][W-1:0]               i_vec,
    output logic [2:0][hvn_pkg::NORM_W-1:0] o_vec,
    output logic                            o_zero
);

    localparam int MW      = (W > hvn_pkg::MANT_W) ? W : hvn_pkg::MANT_W;
    localparam int PW      = $clog2(MW);
    localparam int TOP_BIT = hvn_pkg::MANT_W - 1;
    localparam int MANT_W  = hvn_pkg::MANT_W;
    localparam int ROOT_W  = hvn_pkg::ROOT_W;
    localparam int REM_W   = hvn_pkg::REM_W;
    localparam int SUM_W   = hvn_pkg::SUM_W;
    localparam int RAD_W   = hvn_pkg::RAD_W;
    localparam int NUM_W   = hvn_pkg::NUM_W;
    localparam int NORM_W  = hvn_pkg::NORM_W;
    localparam int DREM_W  = hvn_pkg::DREM_W;
    localparam logic [NORM_W-1:0] POS_MAX = {1'b0, {(NORM_W-1){1'b1}}};
    localparam logic [NORM_W-1:0] NEG_MIN = {1'b1, {(NORM_W-1){1'b0}}};

    typedef struct packed {
        logic [2:0][MANT_W-1:0] m;
        logic [2:0]             neg;
        logic                   zero;
    } t_side;

    typedef struct packed {
        logic [2:0] neg;
        logic       zero;
    } t_flags;

    // stage 1: magnitudes and largest one
    logic [2:0][W-1:0]  n_s1_abs;
    logic [2:0][MW-1:0] n_s1_mag;
    logic [MW-1:0]      n_s1_top;
    logic [2:0][MW-1:0] r_s1_mag;
    logic [2:0]         r_s1_neg;
    logic [MW-1:0]      r_s1_top;

    always_comb begin
        n_s1_top = '0;
        for (int k = 0; k < 3; k++) begin
            n_s1_abs[k] = i_vec[k][W-1] ? (~i_vec[k] + 1'b1) : i_vec[k];
            n_s1_mag[k] = MW'(n_s1_abs[k]);
            if (n_s1_mag[k] > n_s1_top) begin
                n_s1_top = n_s1_mag[k];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_s1_mag <= n_s1_mag;
            for (int k = 0; k < 3; k++) begin
                r_s1_neg[k] <= i_vec[k][W-1];
            end
            r_s1_top <= n_s1_top;
        end
    end

    // stage 2: leading one of the largest magnitude
    logic [PW-1:0]      n_s2_pos;
    logic [2:0][MW-1:0] r_s2_mag;
    logic [2:0]         r_s2_neg;
    logic [PW-1:0]      r_s2_pos;
    logic               r_s2_zero;

    always_comb begin
        n_s2_pos = '0;
        for (int b = 0; b < MW; b++) begin
            if (r_s1_top[b]) begin
                n_s2_pos = PW'(b);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_s2_mag  <= r_s1_mag;
            r_s2_neg  <= r_s1_neg;
            r_s2_pos  <= n_s2_pos;
            r_s2_zero <= (r_s1_top == '0);
        end
    end

    // stage 3: common shift so the largest lands in [2^19, 2^20)
    logic [2:0][MW-1:0] n_s3_sh;
    t_side              n_s3_side;
    t_side              r_s3_side;

    always_comb begin
        for (int k = 0; k < 3; k++) begin
            if (r_s2_pos >= PW'(TOP_BIT)) begin
                n_s3_sh[k] = r_s2_mag[k] >> (r_s2_pos - PW'(TOP_BIT));
            end else begin
                n_s3_sh[k] = r_s2_mag[k] << (PW'(TOP_BIT) - r_s2_pos);
            end
            n_s3_side.m[k] = n_s3_sh[k][MANT_W-1:0];
        end
        n_s3_side.neg  = r_s2_neg;
        n_s3_side.zero = r_s2_zero;
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_s3_side <= n_s3_side;
        end
    end

    // stage 4: squares, stage 5: sum of squares
    logic [2:0][hvn_pkg::SQ_W-1:0] r_s4_sq;
    t_side                         r_s4_side;
    logic [SUM_W-1:0]              r_s5_sum;
    t_side                         r_s5_side;

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            for (int k = 0; k < 3; k++) begin
                r_s4_sq[k] <= hvn_pkg::SQ_W'(r_s3_side.m[k]) * hvn_pkg::SQ_W'(r_s3_side.m[k]);
            end
            r_s4_side <= r_s3_side;
            r_s5_sum  <= SUM_W'(r_s4_sq[0]) + SUM_W'(r_s4_sq[1]) + SUM_W'(r_s4_sq[2]);
            r_s5_side <= r_s4_side;
        end
    end

    // square root of sum * 2^20, one result bit per stage
    logic [REM_W-1:0]  r_sq_rem  [ROOT_W];
    logic [ROOT_W-1:0] r_sq_root [ROOT_W];
    logic [SUM_W-1:0]  r_sq_sum  [ROOT_W];
    t_side             r_sq_side [ROOT_W];

    for (genvar k = 0; k < ROOT_W; k++) begin : g_sqrt
        localparam int PI = ROOT_W - 1 - k;
        logic [REM_W-1:0]  v_rem_in;
        logic [ROOT_W-1:0] v_root_in;
        logic [SUM_W-1:0]  v_sum_in;
        t_side             v_side_in;
        logic [RAD_W-1:0]  v_rad;
        logic [REM_W-1:0]  v_rs;
        logic [REM_W-1:0]  v_try;
        logic [REM_W-1:0]  n_rem;
        logic [ROOT_W-1:0] n_root;

        if (k == 0) begin : g_first
            assign v_rem_in  = '0;
            assign v_root_in = '0;
            assign v_sum_in  = r_s5_sum;
            assign v_side_in = r_s5_side;
        end else begin : g_next
            assign v_rem_in  = r_sq_rem[k-1];
            assign v_root_in = r_sq_root[k-1];
            assign v_sum_in  = r_sq_sum[k-1];
            assign v_side_in = r_sq_side[k-1];
        end

        always_comb begin
            v_rad = {v_sum_in, {MANT_W{1'b0}}};
            v_rs  = {v_rem_in[REM_W-3:0], v_rad[2*PI +: 2]};
            v_try = REM_W'({v_root_in, 2'b01});
            if (v_rs >= v_try) begin
                n_rem  = v_rs - v_try;
                n_root = {v_root_in[ROOT_W-2:0], 1'b1};
            end else begin
                n_rem  = v_rs;
                n_root = {v_root_in[ROOT_W-2:0], 1'b0};
            end
        end

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_sq_rem[k]  <= n_rem;
                r_sq_root[k] <= n_root;
                r_sq_sum[k]  <= v_sum_in;
                r_sq_side[k] <= v_side_in;
            end
        end
    end

    // numerators m * 2^25 + L/2
    logic [2:0][NUM_W-1:0] r_nu_num;
    logic [ROOT_W-1:0]     r_nu_len;
    t_flags                r_nu_flags;

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            for (int k = 0; k < 3; k++) begin
                r_nu_num[k] <= NUM_W'({r_sq_side[ROOT_W-1].m[k], {hvn_pkg::NUM_SHIFT{1'b0}}})
                             + NUM_W'(r_sq_root[ROOT_W-1] >> 1);
            end
            r_nu_len        <= r_sq_root[ROOT_W-1];
            r_nu_flags.neg  <= r_sq_side[ROOT_W-1].neg;
            r_nu_flags.zero <= r_sq_side[ROOT_W-1].zero;
        end
    end

    // restoring division, one quotient bit per stage
    logic [2:0][DREM_W-1:0] r_dv_rem   [NORM_W];
    logic [2:0][NORM_W-1:0] r_dv_quo   [NORM_W];
    logic [2:0][NUM_W-1:0]  r_dv_num   [NORM_W];
    logic [ROOT_W-1:0]      r_dv_len   [NORM_W];
    t_flags                 r_dv_flags [NORM_W];

    for (genvar j = 0; j < NORM_W; j++) begin : g_div
        localparam int BI = NORM_W - 1 - j;
        logic [2:0][DREM_W-1:0] v_rem_in;
        logic [2:0][NORM_W-1:0] v_quo_in;
        logic [2:0][NUM_W-1:0]  v_num_in;
        logic [ROOT_W-1:0]      v_len_in;
        t_flags                 v_flags_in;
        logic [2:0][DREM_W-1:0] v_rs;
        logic [2:0][DREM_W-1:0] n_rem;
        logic [2:0][NORM_W-1:0] n_quo;

        if (j == 0) begin : g_first
            for (genvar k = 0; k < 3; k++) begin : g_lane
                assign v_rem_in[k] = DREM_W'(r_nu_num[k][NUM_W-1:NORM_W]);
            end
            assign v_quo_in   = '0;
            assign v_num_in   = r_nu_num;
            assign v_len_in   = r_nu_len;
            assign v_flags_in = r_nu_flags;
        end else begin : g_next
            assign v_rem_in   = r_dv_rem[j-1];
            assign v_quo_in   = r_dv_quo[j-1];
            assign v_num_in   = r_dv_num[j-1];
            assign v_len_in   = r_dv_len[j-1];
            assign v_flags_in = r_dv_flags[j-1];
        end

        always_comb begin
            for (int k = 0; k < 3; k++) begin
                v_rs[k] = {v_rem_in[k][DREM_W-2:0], v_num_in[k][BI]};
                if (v_rs[k] >= DREM_W'(v_len_in)) begin
                    n_rem[k] = v_rs[k] - DREM_W'(v_len_in);
                    n_quo[k] = {v_quo_in[k][NORM_W-2:0], 1'b1};
                end else begin
                    n_rem[k] = v_rs[k];
                    n_quo[k] = {v_quo_in[k][NORM_W-2:0], 1'b0};
                end
            end
        end

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_dv_rem[j]   <= n_rem;
                r_dv_quo[j]   <= n_quo;
                r_dv_num[j]   <= v_num_in;
                r_dv_len[j]   <= v_len_in;
                r_dv_flags[j] <= v_flags_in;
            end
        end
    end

    // sign and saturation
    logic [2:0][NORM_W-1:0] n_out;
    logic [2:0][NORM_W-1:0] r_out;
    logic                   r_out_zero;

    always_comb begin
        for (int k = 0; k < 3; k++) begin
            if (r_dv_flags[NORM_W-1].zero) begin
                n_out[k] = '0;
            end else if (!r_dv_flags[NORM_W-1].neg[k]) begin
                n_out[k] = (r_dv_quo[NORM_W-1][k] > POS_MAX) ? POS_MAX : r_dv_quo[NORM_W-1][k];
            end else if (r_dv_quo[NORM_W-1][k] > NEG_MIN) begin
                n_out[k] = NEG_MIN;
            end else begin
                n_out[k] = ~r_dv_quo[NORM_W-1][k] + 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_out      <= n_out;
            r_out_zero <= r_dv_flags[NORM_W-1].zero;
        end
    end

    assign o_vec  = r_out;
    assign o_zero = r_out_zero;

endmodule

/* verif/tb_top.sv */
// Testbench for heightfield_vertex_normal_unit: random and directed vertex requests,
// an in-bench normal predictor, and a scoreboard on the result channel.
// Depends on hvn_pkg and the unit's RTL.
`timescale 1ns / 1ps

module tb_top;

    localparam int HW        = hvn_pkg::HEIGHT_WIDTH_DEF;
    localparam int LAT       = 2 * hvn_pkg::NORM_LAT + 3;
    localparam int POS_W     = hvn_pkg::POS_W;
    localparam int REG_W     = hvn_pkg::REG_W;
    localparam int NORM_W    = hvn_pkg::NORM_W;
    localparam int CFG_IDX_W = hvn_pkg::CFG_IDX_W;
    localparam int GRID_STEP = hvn_pkg::GRID_STEP;
    localparam int LIMIT     = 400000;
    localparam int HOLD_LEN  = 400;

    typedef struct {
        logic [POS_W-1:0]     row;
        logic [POS_W-1:0]     col;
        logic signed [HW-1:0] h [7];  // center, n, ne, e, s, sw, w
    } t_vertex;

    typedef struct {
        logic signed [NORM_W-1:0] nx;
        logic signed [NORM_W-1:0] ny;
        logic signed [NORM_W-1:0] nz;
        logic                     inv;
    } t_normal;

    logic                    i_clk = 0;
    logic                    i_rst_n = 0;
    logic                    i_cfg_we = 0;
    logic [CFG_IDX_W-1:0]    i_cfg_idx = hvn_pkg::CFG_GRID_WIDTH;
    logic [REG_W-1:0]        i_cfg_data = '0;
    logic                    i_valid = 0;
    logic                    o_ready;
    logic [POS_W-1:0]        i_row = '0;
    logic [POS_W-1:0]        i_col = '0;
    logic signed [HW-1:0]    i_hts [7] = '{default: '0};
    logic                    o_valid;
    logic                    i_ready = 0;
    logic signed [NORM_W-1:0] o_normal_x, o_normal_y, o_normal_z;
    logic                    o_invalid;

    t_vertex  vertex_q [$];
    t_normal  normal_q [$];
    t_vertex  cur_vtx;
    int       n_err = 0;
    int       cycles = 0;
    bit       calm = 0;
    int       hold_req = 0, hold_done = 0;
    int       src_gap = 0, snk_gap = 0, hold_cnt = 0;
    logic [REG_W-1:0] cur_w = REG_W'(hvn_pkg::GRID_SIDE_MAX_DEF);
    logic [REG_W-1:0] cur_h = REG_W'(hvn_pkg::GRID_SIDE_MAX_DEF);

    heightfield_vertex_normal_unit u_dut (
        .i_clk, .i_rst_n, .i_cfg_we, .i_cfg_idx, .i_cfg_data,
        .i_valid, .o_ready, .i_row, .i_col,
        .i_center_height(i_hts[0]), .i_north_height(i_hts[1]),
        .i_north_east_height(i_hts[2]), .i_east_height(i_hts[3]),
        .i_south_height(i_hts[4]), .i_south_west_height(i_hts[5]),
        .i_west_height(i_hts[6]),
        .o_valid, .i_ready, .o_normal_x, .o_normal_y, .o_normal_z, .o_invalid
    );

    initial forever #1 i_clk = ~i_clk;

    function automatic longint unsigned int_sqrt(input longint unsigned x);
        longint unsigned res, bitv;
        res = 0;
        bitv = 64'd1 << 62;
        while (bitv > x) bitv >>= 2;
        while (bitv != 0) begin
            if (x >= res + bitv) begin
                x -= res + bitv;
                res = (res >> 1) + bitv;
            end else begin
                res >>= 1;
            end
            bitv >>= 2;
        end
        return res;
    endfunction

    // Q1.15 unit vector; nz = 0 for the zero vector
    function automatic void unit_vec(input longint v [3], output longint n [3],
                                     output bit nz);
        longint unsigned m [3];
        longint unsigned top, s, len, q;
        longint r;
        int sh;
        top = 0; s = 0; sh = 0;
        for (int k = 0; k < 3; k++) begin
            m[k] = v[k] < 0 ? -v[k] : v[k];
            if (m[k] > top) top = m[k];
            n[k] = 0;
        end
        nz = (top != 0);
        if (!nz) return;
        while (top >= (64'd1 << 20)) begin top >>= 1; sh++; end
        for (int k = 0; k < 3; k++) m[k] >>= sh;
        sh = 0;
        while (top < (64'd1 << 19)) begin top <<= 1; sh++; end
        for (int k = 0; k < 3; k++) begin
            m[k] <<= sh;
            s += m[k] * m[k];
        end
        len = int_sqrt(s << 20);
        for (int k = 0; k < 3; k++) begin
            q = ((m[k] << 25) + len / 2) / len;
            r = longint'(q);
            if (v[k] < 0) r = -r;
            if (r > 32767) r = 32767;
            if (r < -32768) r = -32768;
            n[k] = r;
        end
    endfunction

    function automatic void add_face(input longint a [3], input longint b [3],
                                     inout longint acc [3]);
        longint c [3], n [3];
        bit nz;
        c[0] = a[1] * b[2] - a[2] * b[1];
        c[1] = a[2] * b[0] - a[0] * b[2];
        c[2] = a[0] * b[1] - a[1] * b[0];
        unit_vec(c, n, nz);
        for (int k = 0; k < 3; k++) acc[k] += n[k];
    endfunction

    function automatic t_normal vertex_normal(input t_vertex v);
        longint en [3], ene [3], ee [3], es [3], esw [3], ew [3];
        longint acc [3], neg [3], res [3];
        longint hc;
        bit has_n, has_s, has_w, has_e, nz;
        int cnt;
        t_normal o;
        hc = v.h[0];
        en  = '{0, longint'(v.h[1]) - hc, -GRID_STEP};
        ene = '{GRID_STEP, longint'(v.h[2]) - hc, -GRID_STEP};
        ee  = '{GRID_STEP, longint'(v.h[3]) - hc, 0};
        es  = '{0, longint'(v.h[4]) - hc, GRID_STEP};
        esw = '{-GRID_STEP, longint'(v.h[5]) - hc, GRID_STEP};
        ew  = '{-GRID_STEP, longint'(v.h[6]) - hc, 0};
        acc = '{0, 0, 0};
        res = '{0, 0, 0};
        cnt = 0;
        nz = 0;
        if (v.row < cur_h && v.col < cur_w) begin
            has_n = v.row > 0;
            has_s = 32'(v.row) + 1 < 32'(cur_h);
            has_w = v.col > 0;
            has_e = 32'(v.col) + 1 < 32'(cur_w);
            if (has_n && has_w) begin add_face(ew, en, acc); cnt++; end
            if (has_n && has_e) begin
                add_face(en, ene, acc); add_face(ene, ee, acc); cnt += 2;
            end
            if (has_s && has_e) begin add_face(ee, es, acc); cnt++; end
            if (has_s && has_w) begin
                add_face(es, esw, acc); add_face(esw, ew, acc); cnt += 2;
            end
            if (cnt > 0) begin
                for (int k = 0; k < 3; k++) neg[k] = -acc[k];
                unit_vec(neg, res, nz);
            end
        end
        if (!nz) res = '{0, 0, 0};
        o.nx = res[0][15:0];
        o.ny = res[1][15:0];
        o.nz = res[2][15:0];
        o.inv = !nz;
        return o;
    endfunction

    // request driver
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_valid <= 0;
            src_gap <= 0;
        end else begin
            if (i_valid && o_ready) normal_q.insert(normal_q.size(), vertex_normal(cur_vtx));
            if (!i_valid || o_ready) begin
                if (src_gap > 0) begin
                    src_gap <= src_gap - 1;
                    i_valid <= 0;
                end else if (!calm && $urandom_range(0, 11) == 0) begin
                    src_gap <= $urandom_range(0, 14);
                    i_valid <= 0;
                end else if (vertex_q.size() > 0) begin
                    cur_vtx = vertex_q.pop_front();
                    i_row <= cur_vtx.row;
                    i_col <= cur_vtx.col;
                    for (int k = 0; k < 7; k++) i_hts[k] <= cur_vtx.h[k];
                    i_valid <= 1;
                end else begin
                    i_valid <= 0;
                end
            end
        end
    end

    // result monitor and scoreboard
    always @(posedge i_clk) begin
        t_normal e;
        if (!i_rst_n) begin
            i_ready <= 0;
        end else begin
            if (o_valid && i_ready) begin
                if (normal_q.size() == 0) begin
                    $display("%0t: result with no request pending", $realtime);
                    n_err++;
                end else begin
                    e = normal_q.pop_front();
                    if (o_normal_x !== e.nx) begin
                        $display("%0t: normal_x exp %0d got %0d", $realtime, e.nx, o_normal_x);
                        n_err++;
                    end
                    if (o_normal_y !== e.ny) begin
                        $display("%0t: normal_y exp %0d got %0d", $realtime, e.ny, o_normal_y);
                        n_err++;
                    end
                    if (o_normal_z !== e.nz) begin
                        $display("%0t: normal_z exp %0d got %0d", $realtime, e.nz, o_normal_z);
                        n_err++;
                    end
                    if (o_invalid !== e.inv) begin
                        $display("%0t: invalid exp %0d got %0d", $realtime, e.inv, o_invalid);
                        n_err++;
                    end
                end
            end
            if (hold_cnt > 0) begin
                hold_cnt <= hold_cnt - 1;
                i_ready <= (hold_cnt == 1);
            end else if (hold_req != hold_done) begin
                hold_done <= hold_done + 1;
                hold_cnt <= HOLD_LEN;
                i_ready <= 0;
            end else if (snk_gap > 0) begin
                snk_gap <= snk_gap - 1;
                i_ready <= (snk_gap == 1);
            end else if (!calm && $urandom_range(0, 9) == 0) begin
                snk_gap <= $urandom_range(1, 15);
                i_ready <= 0;
            end else begin
                i_ready <= 1;
            end
        end
    end

    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles > LIMIT) begin
            $display("heightfield_vertex_normal_unit test failed");
            $finish;
        end
    end

    function automatic logic signed [HW-1:0] clamp_ht(input int x);
        if (x > 32767) return 16'sh7fff;
        if (x < -32768) return 16'sh8000;
        return x[HW-1:0];
    endfunction

    function automatic logic [POS_W-1:0] pick_pos(input logic [REG_W-1:0] side);
        int r;
        r = $urandom_range(0, 9);
        if (side == 0 || r == 0) return POS_W'($urandom_range(0, 1023));
        if (r == 1) return '0;
        if (r == 2) return (side > 1024) ? POS_W'(1023) : POS_W'(side - 1'b1);
        return POS_W'($urandom_range(0, (side > 1024 ? 1024 : side) - 1));
    endfunction

    task automatic add_vtx(input int row, input int col, input int hc, input int hn,
                           input int hne, input int he, input int hs, input int hsw,
                           input int hw);
        t_vertex v;
        v.row = POS_W'(row); v.col = POS_W'(col);
        v.h[0] = clamp_ht(hc); v.h[1] = clamp_ht(hn); v.h[2] = clamp_ht(hne);
        v.h[3] = clamp_ht(he); v.h[4] = clamp_ht(hs); v.h[5] = clamp_ht(hsw);
        v.h[6] = clamp_ht(hw);
        vertex_q.insert(vertex_q.size(), v);
    endtask

    task automatic add_random(input int n);
        t_vertex v;
        int c, spread, mode;
        repeat (n) begin
            v.row = pick_pos(cur_h);
            v.col = pick_pos(cur_w);
            mode = $urandom_range(0, 9);
            c = int'($urandom_range(0, 65535)) - 32768;
            spread = 1 << $urandom_range(0, 12);
            for (int k = 0; k < 7; k++) begin
                if (mode < 3) v.h[k] = HW'($urandom_range(0, 65535));
                else if (mode == 3) v.h[k] = ($urandom_range(0, 1)) ? 16'sh7fff : 16'sh8000;
                else v.h[k] = clamp_ht(k == 0 ? c :
                                       c + int'($urandom_range(0, 2 * spread)) - spread);
            end
            vertex_q.insert(vertex_q.size(), v);
        end
    endtask

    task automatic wait_idle();
        do @(negedge i_clk);
        while (vertex_q.size() != 0 || i_valid || normal_q.size() != 0);
        repeat (LAT + 10) @(posedge i_clk);
    endtask

    task automatic set_grid(input logic [REG_W-1:0] w, input logic [REG_W-1:0] h);
        @(posedge i_clk);
        i_cfg_we <= 1; i_cfg_idx <= hvn_pkg::CFG_GRID_WIDTH; i_cfg_data <= w;
        @(posedge i_clk);
        i_cfg_idx <= hvn_pkg::CFG_GRID_HEIGHT; i_cfg_data <= h;
        @(posedge i_clk);
        i_cfg_we <= 0;
        cur_w = w; cur_h = h;
        @(negedge i_clk);
    endtask

    initial begin
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1;
        @(negedge i_clk);

        // reset grid: corners, edges, flat and steep interiors
        add_vtx(0, 0, 0, 100, 200, 300, 400, 500, 600);
        add_vtx(0, 1023, 0, 0, 0, 0, 0, 0, 0);
        add_vtx(1023, 0, 256, -256, 512, 0, 1000, -1000, 7);
        add_vtx(1023, 1023, 0, 0, 0, 0, 0, 0, 0);
        add_vtx(500, 500, 0, 0, 0, 0, 0, 0, 0);
        add_vtx(500, 500, -32768, 32767, 32767, 32767, 32767, 32767, 32767);
        add_vtx(511, 512, 32767, -32768, -32768, -32768, -32768, -32768, -32768);
        add_vtx(1, 1, 32767, -32768, 32767, -32768, 32767, -32768, 32767);
        add_vtx(0, 600, 0, 0, 0, 256, -256, 0, 0);
        add_vtx(600, 0, 10, 20, 30, 40, 50, 60, 70);
        add_vtx(682, 341, 0, 1, -1, 1, -1, 1, -1);
        wait_idle();

        set_grid(1, 1);
        add_vtx(0, 0, 0, 0, 0, 0, 0, 0, 0);
        add_vtx(5, 5, 0, 0, 0, 0, 0, 0, 0);
        wait_idle();
        set_grid(0, 5);
        add_vtx(0, 0, 0, 0, 0, 0, 0, 0, 0);
        wait_idle();
        set_grid(1, 4);
        add_vtx(2, 0, 0, 9, 9, 9, 9, 9, 9);
        wait_idle();
        set_grid(2, 2);
        add_vtx(0, 0, 0, 100, 0, 0, 0, 0, 0);
        add_vtx(1, 1, 0, 100, 300, 50, 0, -70, 0);
        add_vtx(2, 1, 0, 0, 0, 0, 0, 0, 0);
        wait_idle();
        set_grid(2047, 2047);
        add_vtx(1023, 1023, 0, 500, 0, 0, 0, 0, 0);
        wait_idle();

        set_grid(1024, 1024);
        hold_req = 1;
        add_random(250);
        wait_idle();
        for (int ph = 0; ph < 5; ph++) begin
            set_grid(REG_W'($urandom_range(1, 64) + (ph == 4 ? 960 : 0)),
                     REG_W'($urandom_range(1, ph == 2 ? 3 : 1024)));
            add_random(250);
            wait_idle();
        end
        set_grid(1024, 1024);
        calm = 1;
        add_random(250);
        wait_idle();

        if (n_err == 0) begin
            $display("heightfield_vertex_normal_unit test passed");
        end else begin
            $display("heightfield_vertex_normal_unit test failed");
        end
        $finish;
    end

endmodule

/* filelist.f */
design/hvn_pkg.sv
design/hvn_norm.sv
design/heightfield_vertex_normal_unit.sv
verif/tb_top.sv
